### sv/scalar_kalman_filter_unit_macros.svh
// Assertion macros shared by the scalar Kalman filter RTL.
`ifndef SCALAR_KALMAN_FILTER_UNIT_MACROS_SVH
`define SCALAR_KALMAN_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SKF_ASSERT_IMPL(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset.
`define SKF_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle implication failed");

`endif

### sv/skf_pkg.sv
// Shared widths and register codes of the scalar Kalman filter.
`default_nettype none

package skf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int EST_W     = 32;
    localparam int VAR_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;

    localparam logic signed [EST_W-1:0] EST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [EST_W-1:0] EST_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

### sv/skf_divider.sv
// Restoring divider that forms the filter gain one quotient bit per cycle.
`default_nettype none

module skf_divider #(
    parameter int QUOT_W = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [skf_pkg::VAR_W-1:0]     i_num,
    input  logic [skf_pkg::VAR_W:0]       i_den,
    output logic                          o_done,
    output logic [QUOT_W-1:0]             o_quot
);

    localparam int REM_W = skf_pkg::VAR_W + 2;
    localparam int DEN_W = skf_pkg::VAR_W + 1;
    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [QUOT_W-1:0] QUOT_ONE = QUOT_W'(1) << (QUOT_W - 1);

    logic [REM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_zero;

    logic [REM_W:0]   w_trial;
    logic             w_ge;
    logic [REM_W-1:0] w_rem_sel;
    logic [REM_W-1:0] w_den2;

    assign w_trial   = {1'b0, r_rem} - {2'b00, r_den};
    assign w_ge      = ~w_trial[REM_W];
    assign w_rem_sel = w_ge ? w_trial[REM_W-1:0] : r_rem;
    assign w_den2    = {r_den, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {2'b00, i_num};
                r_den  <= i_den;
                r_zero <= (i_den == '0);
                r_quot <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quot <= {r_quot[QUOT_W-2:0], w_ge};
                r_rem  <= {w_rem_sel[REM_W-2:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // A zero denominator would fill the quotient with ones; it means zero gain.
    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_quot;

    `include "scalar_kalman_filter_unit_macros.svh"

    `SKF_ASSERT_IMPL(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy)
    `SKF_ASSERT_IMPL(a_gain_at_most_one, i_clk, i_rst_n, o_done, o_quot <= QUOT_ONE)
    `SKF_ASSERT_IMPL(a_rem_bounded, i_clk, i_rst_n, r_busy, r_rem <= w_den2)

endmodule

`default_nettype wire

### sv/scalar_kalman_filter_unit.sv
// Top level of the scalar Kalman filter: sequencer, predict, update and output stage.
//
// Use: samples arrive on the input channel (i_in_valid, o_in_stall, i_sample); a
// transfer takes place at a rising edge with valid high and stall low. Each sample
// yields exactly one filtered estimate on the output channel (o_out_valid,
// i_out_stall, o_estimate), signed with FRAC_BITS fraction bits.
// The user must write Q and R through i_cfg_we, i_cfg_index and i_cfg_data
// only while idle; the block itself does not enforce it. Each estimate passes a
// predict step, the restoring gain divider plus its start and finish, the two
// shift-and-add multipliers and a rounding step. The sample rate is set by the
// serial divider and the serial multipliers, which handle one gain bit per cycle.
// The input stalls while a sample is in work and is free again as soon as the
// result sits in the output register, so a new sample may be taken while the
// previous estimate still waits for the receiver.
// If the receiver stalls and the output register is still full when the next
// result is ready, the block holds that result until the register frees up.
// Reset (synchronous, active low) clears the estimate, the variance, Q, R and
// all handshake state.
`default_nettype none

module scalar_kalman_filter_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [skf_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [skf_pkg::EST_W-1:0]     o_estimate,
    input  logic                                 i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [skf_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int EST_W  = skf_pkg::EST_W;
    localparam int VAR_W  = skf_pkg::VAR_W;
    localparam int GAIN_W = FRAC_BITS + 1;
    localparam int DIFF_W = EST_W + 1;
    localparam int AE_W   = DIFF_W + GAIN_W + 1;
    localparam int AV_W   = VAR_W + GAIN_W;
    localparam int STEP_W = AE_W - FRAC_BITS;
    localparam int SUM_W  = STEP_W + 1;
    localparam int MW     = skf_pkg::SAMPLE_W + FRAC_BITS;
    localparam int CW     = (MW > EST_W) ? MW : EST_W;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);

    localparam logic [GAIN_W-1:0]       GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
    localparam logic signed [AE_W-1:0]  HALF_E   = AE_W'(1) << (FRAC_BITS - 1);
    localparam logic [AV_W-1:0]         HALF_V   = AV_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [CW-1:0]    MEAS_MAX = CW'(skf_pkg::EST_MAX);
    localparam logic signed [CW-1:0]    MEAS_MIN = CW'(skf_pkg::EST_MIN);
    localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'(skf_pkg::EST_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN  = SUM_W'(skf_pkg::EST_MIN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRED,
        S_DIV,
        S_MUL,
        S_FIN
    } t_state;

    t_state r_state;

    // Filter state and configuration.
    logic signed [EST_W-1:0]  r_est;
    logic [VAR_W-1:0]         r_var;
    logic [skf_pkg::CFG_W-1:0] r_q;
    logic [skf_pkg::CFG_W-1:0] r_r;

    // Working registers of one sample.
    logic signed [skf_pkg::SAMPLE_W-1:0] r_sample;
    logic [VAR_W-1:0]         r_p;
    logic signed [DIFF_W-1:0] r_diff;
    logic                     r_div_start;
    logic [GAIN_W-1:0]        r_gsh;
    logic [GAIN_W-1:0]        r_csh;
    logic signed [AE_W-1:0]   r_acc_e;
    logic [AV_W-1:0]          r_acc_v;
    logic [CNT_W-1:0]         r_mcnt;

    // Output register.
    logic                     r_out_valid;
    logic signed [EST_W-1:0]  r_out_est;

    logic [VAR_W:0]           w_p_sum;
    logic [VAR_W-1:0]         n_p;
    logic [VAR_W:0]           w_den;
    logic signed [CW-1:0]     w_meas_full;
    logic signed [EST_W-1:0]  w_meas;
    logic signed [DIFF_W-1:0] n_diff;
    logic                     w_div_done;
    logic [GAIN_W-1:0]        w_gain;
    logic signed [AE_W-1:0]   w_pp_e;
    logic [AV_W-1:0]          w_pp_v;
    logic signed [AE_W-1:0]   w_est_rnd;
    logic signed [AE_W-1:0]   w_est_shift;
    logic signed [STEP_W-1:0] w_step;
    logic signed [SUM_W-1:0]  w_est_sum;
    logic signed [EST_W-1:0]  n_est;
    logic [AV_W-1:0]          w_var_rnd;
    logic [AV_W-FRAC_BITS-1:0] w_var_q;
    logic [VAR_W-1:0]         n_var;
    logic                     w_out_free;

    // Predict: the variance grows by Q and saturates at full scale.
    assign w_p_sum = {1'b0, r_var} + {1'b0, r_q};
    assign n_p     = w_p_sum[VAR_W] ? '1 : w_p_sum[VAR_W-1:0];
    assign w_den   = {1'b0, r_p} + {1'b0, r_r};

    // The scaled sample can only leave the estimate range for wide fractions.
    assign w_meas_full = CW'(r_sample) <<< FRAC_BITS;

    always_comb begin
        if (w_meas_full > MEAS_MAX) begin
            w_meas = skf_pkg::EST_MAX;
        end else if (w_meas_full < MEAS_MIN) begin
            w_meas = skf_pkg::EST_MIN;
        end else begin
            w_meas = w_meas_full[EST_W-1:0];
        end
    end

    assign n_diff = DIFF_W'(w_meas) - DIFF_W'(r_est);

    skf_divider #(
        .QUOT_W (GAIN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_p),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_gain)
    );

    // Partial products of the two MSB-first shift-and-add multipliers.
    always_comb begin
        w_pp_e = '0;
        w_pp_v = '0;
        if (r_gsh[GAIN_W-1]) begin
            w_pp_e = AE_W'(r_diff);
        end
        if (r_csh[GAIN_W-1]) begin
            w_pp_v = AV_W'(r_p);
        end
    end

    // Round half up on both products, then clamp the estimate for safety.
    assign w_est_rnd   = r_acc_e + HALF_E;
    assign w_est_shift = w_est_rnd >>> FRAC_BITS;
    assign w_step      = $signed(w_est_shift[STEP_W-1:0]);
    assign w_est_sum   = SUM_W'(r_est) + SUM_W'(w_step);

    always_comb begin
        if (w_est_sum > SUM_MAX) begin
            n_est = skf_pkg::EST_MAX;
        end else if (w_est_sum < SUM_MIN) begin
            n_est = skf_pkg::EST_MIN;
        end else begin
            n_est = w_est_sum[EST_W-1:0];
        end
    end

    assign w_var_rnd = r_acc_v + HALF_V;
    assign w_var_q   = w_var_rnd[AV_W-1:FRAC_BITS];
    assign n_var     = (w_var_q[AV_W-FRAC_BITS-1:VAR_W] != '0) ? '1 : w_var_q[VAR_W-1:0];

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_est       <= '0;
            r_var       <= '0;
            r_q         <= '0;
            r_r         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    skf_pkg::REG_PROCESS_NOISE: r_q <= i_cfg_data;
                    skf_pkg::REG_MEASURE_NOISE: r_r <= i_cfg_data;
                    default: ;
                endcase
            end

            // The divider starts on the cycle after the predict step.
            r_div_start <= (r_state == S_PRED);
            if (r_out_valid && !i_out_stall && !((r_state == S_FIN) && w_out_free)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sample <= i_sample;
                        r_state  <= S_PRED;
                    end
                end
                S_PRED: begin
                    r_p         <= n_p;
                    r_diff      <= n_diff;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_gsh   <= w_gain;
                        r_csh   <= GAIN_ONE - w_gain;
                        r_acc_e <= '0;
                        r_acc_v <= '0;
                        r_mcnt  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc_e <= (r_acc_e <<< 1) + w_pp_e;
                    r_acc_v <= (r_acc_v << 1) + w_pp_v;
                    r_gsh   <= {r_gsh[GAIN_W-2:0], 1'b0};
                    r_csh   <= {r_csh[GAIN_W-2:0], 1'b0};
                    r_mcnt  <= r_mcnt + 1'b1;
                    if (r_mcnt == CNT_W'(FRAC_BITS)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // The state is committed only together with the result.
                    if (w_out_free) begin
                        r_est       <= n_est;
                        r_var       <= n_var;
                        r_out_est   <= n_est;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_out_est;

    `include "scalar_kalman_filter_unit_macros.svh"

    `SKF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_PRED)
    `SKF_ASSERT_IMPL(a_div_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
    `SKF_ASSERT_NEXT(a_fin_delivers, i_clk, i_rst_n, (r_state == S_FIN) && w_out_free, r_out_valid && (r_state == S_IDLE))

endmodule

`default_nettype wire
